>>> rtl/core/psg_pkg.sv
// Shared types and constants for the pulse and sawtooth tone generator.
package psg_pkg;

  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned DATA_W     = 8;
  localparam int unsigned PERIOD_W   = 12;
  localparam int unsigned VOL_W      = 4;
  localparam int unsigned DUTY_W     = 4;
  localparam int unsigned PSTEP_W    = 4;
  localparam int unsigned PCNT_W     = 13;
  localparam int unsigned RATE_W     = 6;
  localparam int unsigned SSTEP_W    = 3;
  localparam int unsigned ACC_W      = 8;
  localparam int unsigned SAW_LVL_W  = 5;
  localparam int unsigned MIX_W      = 6;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 12;

  // Saw counter runs (period + 1) << SAW_PERIOD_SHIFT ticks per step
  localparam int unsigned SAW_PERIOD_SHIFT = 1;
  localparam int unsigned SCNT_W           = PERIOD_W + SAW_PERIOD_SHIFT;

  localparam logic [SSTEP_W-1:0]  SAW_STEPS      = SSTEP_W'(7);
  localparam logic [PERIOD_W-1:0] MIN_PERIOD_RST = PERIOD_W'(4);

  // Item opcodes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Address decode: top nibble selects the channel, low two bits the register
  localparam logic [3:0] ADDR_PULSE_A = 4'h9;
  localparam logic [3:0] ADDR_PULSE_B = 4'hA;
  localparam logic [3:0] ADDR_SAW     = 4'hB;

  localparam logic [1:0] REG_CTRL    = 2'd0;
  localparam logic [1:0] REG_LO      = 2'd1;
  localparam logic [1:0] REG_HI      = 2'd2;
  localparam logic [1:0] REG_UNUSED  = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SWAP_ADDR  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PERIOD = CFG_IDX_W'(1);

  // Per-channel command for one accepted item
  typedef struct packed {
    logic              tick;
    logic              wr;
    logic [1:0]        reg_sel;
    logic [DATA_W-1:0] data;
  } psg_cmd_t;

endpackage

>>> rtl/core/psg_ifs.sv
// Valid/ready channel interfaces for items, results and configuration.
interface psg_in_if;
  import psg_pkg::*;
  logic                valid;
  logic                ready;
  logic                opcode;
  logic [ADDR_W-1:0]   address;
  logic [DATA_W-1:0]   write_data;
  modport source (output valid, opcode, address, write_data, input ready);
  modport sink   (input valid, opcode, address, write_data, output ready);
endinterface

interface psg_out_if;
  import psg_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [VOL_W-1:0]     pulse_level_a;
  logic [VOL_W-1:0]     pulse_level_b;
  logic [SAW_LVL_W-1:0] saw_level;
  logic [MIX_W-1:0]     mixed_level;
  modport source (output valid, pulse_level_a, pulse_level_b, saw_level, mixed_level,
                  input ready);
  modport sink   (input valid, pulse_level_a, pulse_level_b, saw_level, mixed_level,
                  output ready);
endinterface

interface psg_cfg_if;
  import psg_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/pulse_saw_sound_generator.sv
// Top level: input register, address decode, channels, mixer and result register.
//
//  channel | dir | payload                                           | transfer
//  in_i    | in  | opcode, address[15:0], write_data[7:0]            | valid & ready
//  out_o   | out | pulse_level_a/b[3:0], saw_level[4:0], mixed[5:0]  | valid & ready
//  cfg_i   | in  | index[0], data[11:0]                              | valid & ready
//
// An input transfer loads the input register; the channel state update and
// level compute then load the result register, which offers the result.
// One item per cycle sustained while the result is not stalled; each channel
// updates its state once per item. Reset returns channel state and config
// registers to defaults.
// A stalled result holds the input register, which drops ready only when full.
module pulse_saw_sound_generator
  import psg_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  psg_in_if.sink        in_i,
  psg_out_if.source     out_o,
  psg_cfg_if.sink       cfg_i
);

  logic                swap_q;
  logic [PERIOD_W-1:0] min_period_q;

  logic              s1_valid_q;
  logic              s1_opcode_q;
  logic [ADDR_W-1:0] s1_addr_q;
  logic [DATA_W-1:0] s1_data_q;
  logic              s1_adv;

  logic                 out_valid_q;
  logic [VOL_W-1:0]     lvl_a_q, lvl_b_q;
  logic [SAW_LVL_W-1:0] lvl_s_q;
  logic [MIX_W-1:0]     mix_q;

  logic [ADDR_W-1:0]    addr_w;
  logic                 wr_w, tick_w;
  psg_cmd_t             cmd_a, cmd_b, cmd_s;
  logic [VOL_W-1:0]     lvl_a_w, lvl_b_w;
  logic [SAW_LVL_W-1:0] lvl_s_w;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swap_q       <= 1'b0;
      min_period_q <= MIN_PERIOD_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_SWAP_ADDR:  swap_q <= cfg_i.data[0];
        CFG_MIN_PERIOD: min_period_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Input register
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_opcode_q <= in_i.opcode;
      s1_addr_q   <= in_i.address;
      s1_data_q   <= in_i.write_data;
    end
  end

  // Decode
  assign addr_w = swap_q ? {s1_addr_q[ADDR_W-1:2], s1_addr_q[0], s1_addr_q[1]} : s1_addr_q;
  assign wr_w   = s1_adv && (s1_opcode_q == OP_WRITE) && (addr_w[1:0] != REG_UNUSED);
  assign tick_w = s1_adv && (s1_opcode_q == OP_TICK);

  always_comb begin
    cmd_a = '{tick: tick_w, wr: 1'b0, reg_sel: addr_w[1:0], data: s1_data_q};
    cmd_b = cmd_a;
    cmd_s = cmd_a;
    cmd_a.wr = wr_w && (addr_w[ADDR_W-1:ADDR_W-4] == ADDR_PULSE_A);
    cmd_b.wr = wr_w && (addr_w[ADDR_W-1:ADDR_W-4] == ADDR_PULSE_B);
    cmd_s.wr = wr_w && (addr_w[ADDR_W-1:ADDR_W-4] == ADDR_SAW);
  end

  psg_pulse_ch u_pulse_a (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_a),
    .min_period_i(min_period_q),
    .level_o     (lvl_a_w)
  );

  psg_pulse_ch u_pulse_b (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_b),
    .min_period_i(min_period_q),
    .level_o     (lvl_b_w)
  );

  psg_saw_ch u_saw (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_s),
    .min_period_i(min_period_q),
    .level_o     (lvl_s_w)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      lvl_a_q <= lvl_a_w;
      lvl_b_q <= lvl_b_w;
      lvl_s_q <= lvl_s_w;
      mix_q   <= MIX_W'(lvl_a_w) + MIX_W'(lvl_b_w) + MIX_W'(lvl_s_w);
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.pulse_level_a = lvl_a_q;
  assign out_o.pulse_level_b = lvl_b_q;
  assign out_o.saw_level     = lvl_s_q;
  assign out_o.mixed_level   = mix_q;

  a_mix_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (mix_q == MIX_W'(lvl_a_q) + MIX_W'(lvl_b_q) + MIX_W'(lvl_s_q)))
    else $error("mixed level is not the sum of the channel levels");

  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (s1_valid_q && out_valid_q && !out_o.ready))
    else $error("input stalled without a full pipeline");

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_addr_q) && $stable(s1_data_q)
                                 && $stable(s1_opcode_q)))
    else $error("input register changed while stalled");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_a.wr, cmd_b.wr, cmd_s.wr, tick_w}))
    else $error("item drove more than one channel command");

endmodule

>>> rtl/core/psg_pulse_ch.sv
// One pulse channel: registers, countdown, 16-step sequence and level.
module psg_pulse_ch
  import psg_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  psg_cmd_t            cmd_i,
  input  logic [PERIOD_W-1:0] min_period_i,
  output logic [VOL_W-1:0]    level_o
);

  logic [VOL_W-1:0]    volume_q, volume_d;
  logic [DUTY_W-1:0]   duty_q, duty_d;
  logic                digital_q, digital_d;
  logic [PERIOD_W-1:0] period_q, period_d;
  logic                enable_q, enable_d;
  logic [PCNT_W-1:0]   count_q, count_d;
  logic [PSTEP_W-1:0]  step_q, step_d;
  logic                active_q_w, active_d_w;

  assign active_q_w = (volume_q != '0) && enable_q && !digital_q && (period_q >= min_period_i);
  assign active_d_w = (volume_d != '0) && enable_d && !digital_d && (period_d >= min_period_i);

  always_comb begin
    volume_d  = volume_q;
    duty_d    = duty_q;
    digital_d = digital_q;
    period_d  = period_q;
    enable_d  = enable_q;
    count_d   = count_q;
    step_d    = step_q;
    if (cmd_i.wr) begin
      case (cmd_i.reg_sel)
        REG_CTRL: begin
          volume_d  = cmd_i.data[3:0];
          duty_d    = DUTY_W'(cmd_i.data[6:4]) + DUTY_W'(1);
          digital_d = cmd_i.data[7];
        end
        REG_LO: period_d = {period_q[PERIOD_W-1:8], cmd_i.data};
        REG_HI: begin
          period_d = {cmd_i.data[3:0], period_q[7:0]};
          enable_d = cmd_i.data[7];
        end
        default: ;
      endcase
    end else if (cmd_i.tick && active_q_w) begin
      if (count_q == '0) begin
        count_d = PCNT_W'(period_q);
        step_d  = step_q + PSTEP_W'(1);
      end else begin
        count_d = count_q - PCNT_W'(1);
      end
    end
  end

  // Level reflects the state after this item
  assign level_o = (active_d_w && (step_d < duty_d)) ? volume_d : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      volume_q  <= '0;
      duty_q    <= DUTY_W'(1);
      digital_q <= 1'b0;
      period_q  <= PERIOD_W'(1);
      enable_q  <= 1'b0;
      count_q   <= '0;
      step_q    <= '0;
    end else begin
      volume_q  <= volume_d;
      duty_q    <= duty_d;
      digital_q <= digital_d;
      period_q  <= period_d;
      enable_q  <= enable_d;
      count_q   <= count_d;
      step_q    <= step_d;
    end
  end

endmodule

>>> rtl/core/psg_saw_ch.sv
// Sawtooth channel: registers, doubled countdown, 7-step accumulator.
module psg_saw_ch
  import psg_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  psg_cmd_t             cmd_i,
  input  logic [PERIOD_W-1:0]  min_period_i,
  output logic [SAW_LVL_W-1:0] level_o
);

  logic [RATE_W-1:0]   rate_q, rate_d;
  logic [PERIOD_W-1:0] period_q, period_d;
  logic                enable_q, enable_d;
  logic [SCNT_W-1:0]   count_q, count_d;
  logic [SSTEP_W-1:0]  step_q, step_d;
  logic [ACC_W-1:0]    acc_q, acc_d;
  logic [SSTEP_W-1:0]  step_inc;
  logic [SCNT_W:0]     reload_w;
  logic                active_q_w, active_d_w;

  assign active_q_w = enable_q && (rate_q != '0) && (period_q >= min_period_i);
  assign active_d_w = enable_d && (rate_d != '0) && (period_d >= min_period_i);

  assign step_inc = step_q + SSTEP_W'(1);
  // (period + 1) << shift, one bit wider to hold the shifted sum; one is taken off at reload
  assign reload_w = ((SCNT_W+1)'(period_q) + (SCNT_W+1)'(1)) << SAW_PERIOD_SHIFT;

  always_comb begin
    rate_d   = rate_q;
    period_d = period_q;
    enable_d = enable_q;
    count_d  = count_q;
    step_d   = step_q;
    acc_d    = acc_q;
    if (cmd_i.wr) begin
      case (cmd_i.reg_sel)
        REG_CTRL: rate_d = cmd_i.data[RATE_W-1:0];
        REG_LO:   period_d = {period_q[PERIOD_W-1:8], cmd_i.data};
        REG_HI: begin
          period_d = {cmd_i.data[3:0], period_q[7:0]};
          enable_d = cmd_i.data[7];
        end
        default: ;
      endcase
    end else if (cmd_i.tick && active_q_w) begin
      if (count_q == '0) begin
        count_d = SCNT_W'(reload_w - (SCNT_W+1)'(1));
        if (step_inc >= SAW_STEPS) begin
          step_d = '0;
          acc_d  = ACC_W'(rate_q);
        end else begin
          step_d = step_inc;
          acc_d  = acc_q + ACC_W'(rate_q);
        end
      end else begin
        count_d = count_q - SCNT_W'(1);
      end
    end
  end

  assign level_o = active_d_w ? acc_d[ACC_W-1:ACC_W-SAW_LVL_W] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q   <= '0;
      period_q <= PERIOD_W'(1);
      enable_q <= 1'b0;
      count_q  <= '0;
      step_q   <= '0;
      acc_q    <= '0;
    end else begin
      rate_q   <= rate_d;
      period_q <= period_d;
      enable_q <= enable_d;
      count_q  <= count_d;
      step_q   <= step_d;
      acc_q    <= acc_d;
    end
  end

endmodule

>>> tb/pulse_saw_sound_generator_test.sv
// Self-checking testbench for the pulse and sawtooth tone generator.
`timescale 1ns / 1ps

module pulse_saw_sound_generator_test;
  import psg_pkg::*;

  localparam int unsigned ITEMS_PER_PHASE = 265;
  localparam int unsigned NUM_PHASES      = 5;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES    = 4;

  typedef struct packed {
    logic              opcode;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
  } bus_item_t;

  typedef struct packed {
    logic [VOL_W-1:0]     level_a;
    logic [VOL_W-1:0]     level_b;
    logic [SAW_LVL_W-1:0] saw;
    logic [MIX_W-1:0]     mix;
  } tone_levels_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  psg_in_if  in_if ();
  psg_out_if out_if ();
  psg_cfg_if cfg_if ();

  pulse_saw_sound_generator i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predicted tone generator state
  logic                swap_lines;
  logic [PERIOD_W-1:0] min_per;
  logic [VOL_W-1:0]    p_vol   [2];
  logic [DUTY_W-1:0]   p_duty  [2];
  logic                p_dig   [2];
  logic [PERIOD_W-1:0] p_per   [2];
  logic                p_en    [2];
  logic [PCNT_W-1:0]   p_cnt   [2];
  logic [PSTEP_W-1:0]  p_step  [2];
  logic [RATE_W-1:0]   s_rate;
  logic [PERIOD_W-1:0] s_per;
  logic                s_en;
  logic [SCNT_W-1:0]   s_cnt;
  logic [SSTEP_W-1:0]  s_step;
  logic [ACC_W-1:0]    s_acc;

  bus_item_t    pending_items_q [$];
  tone_levels_t expected_levels_q [$];
  bus_item_t    next_item;
  bus_item_t    taken_item;
  tone_levels_t want_levels;

  int  items_queued = 0;
  int  results_seen = 0;
  int  mismatches = 0;
  int  idle_cycles = 0;
  int  in_gap = 0;
  int  out_wait = 0;
  bit  in_idle_on = 1'b1;
  bit  out_idle_on = 1'b1;
  logic in_fire = 1'b0;
  logic out_fire = 1'b0;

  function automatic logic pulse_on(int c);
    return p_vol[c] != '0 && p_en[c] && !p_dig[c] && p_per[c] >= min_per;
  endfunction

  function automatic logic saw_on();
    return s_en && s_rate != '0 && s_per >= min_per;
  endfunction

  function automatic void apply_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] d);
    logic [ADDR_W-1:0] a;
    int c;
    a = addr;
    if (swap_lines)
      a = {addr[ADDR_W-1:2], addr[0], addr[1]};
    if (a[1:0] == REG_UNUSED)
      return;
    if (a[15:12] == ADDR_PULSE_A || a[15:12] == ADDR_PULSE_B) begin
      c = (a[15:12] == ADDR_PULSE_B) ? 1 : 0;
      if (a[1:0] == REG_CTRL) begin
        p_vol[c]  = d[3:0];
        p_duty[c] = DUTY_W'(d[6:4]) + DUTY_W'(1);
        p_dig[c]  = d[7];
      end else if (a[1:0] == REG_LO) begin
        p_per[c] = {p_per[c][11:8], d};
      end else begin
        p_per[c] = {d[3:0], p_per[c][7:0]};
        p_en[c]  = d[7];
      end
    end else if (a[15:12] == ADDR_SAW) begin
      if (a[1:0] == REG_CTRL) begin
        s_rate = d[5:0];
      end else if (a[1:0] == REG_LO) begin
        s_per = {s_per[11:8], d};
      end else begin
        s_per = {d[3:0], s_per[7:0]};
        s_en  = d[7];
      end
    end
  endfunction

  function automatic void advance_clock();
    int nstep;
    for (int c = 0; c < 2; c++) begin
      if (pulse_on(c)) begin
        if (p_cnt[c] == '0) begin
          p_cnt[c]  = PCNT_W'(p_per[c]);
          p_step[c] = p_step[c] + PSTEP_W'(1);
        end else begin
          p_cnt[c] = p_cnt[c] - PCNT_W'(1);
        end
      end
    end
    if (saw_on()) begin
      if (s_cnt == '0) begin
        s_cnt = SCNT_W'(((int'(s_per) + 1) << SAW_PERIOD_SHIFT) - 1);
        nstep = int'(s_step) + 1;
        if (nstep >= int'(SAW_STEPS)) begin
          s_step = '0;
          s_acc  = '0;
        end else begin
          s_step = SSTEP_W'(nstep);
        end
        s_acc = s_acc + ACC_W'(s_rate);
      end else begin
        s_cnt = s_cnt - SCNT_W'(1);
      end
    end
  endfunction

  function automatic tone_levels_t predict_levels(bus_item_t it);
    tone_levels_t lv;
    int sum;
    if (it.opcode == OP_WRITE)
      apply_write(it.address, it.write_data);
    else
      advance_clock();
    lv = '0;
    if (pulse_on(0) && p_step[0] < p_duty[0])
      lv.level_a = p_vol[0];
    if (pulse_on(1) && p_step[1] < p_duty[1])
      lv.level_b = p_vol[1];
    if (saw_on())
      lv.saw = s_acc[ACC_W-1:3];
    sum = int'(lv.level_a) + int'(lv.level_b) + int'(lv.saw);
    lv.mix = MIX_W'(sum);
    return lv;
  endfunction

  task automatic report_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Stimulus helpers
  function automatic void queue_item(logic op, logic [ADDR_W-1:0] addr,
                                     logic [DATA_W-1:0] d);
    bus_item_t it;
    it.opcode     = op;
    it.address    = addr;
    it.write_data = d;
    pending_items_q.push_back(it);
    items_queued++;
  endfunction

  // Register address with random don't-care bits, pre-swapped when swap is on
  function automatic logic [ADDR_W-1:0] chan_addr(int ch, logic [1:0] sel);
    logic [ADDR_W-1:0] a;
    logic [3:0] nib;
    nib = (ch == 0) ? ADDR_PULSE_A : (ch == 1) ? ADDR_PULSE_B : ADDR_SAW;
    a = {nib, 10'($urandom), sel};
    if (swap_lines)
      a = {a[ADDR_W-1:2], a[0], a[1]};
    return a;
  endfunction

  function automatic logic [PERIOD_W-1:0] pick_period();
    int r;
    int p;
    r = $urandom_range(0, 9);
    if (r == 0 || (r == 1 && min_per == '0)) begin
      p = $urandom_range(0, 4095);
    end else if (r == 1) begin
      p = $urandom_range(0, int'(min_per) - 1);
    end else begin
      p = int'(min_per) + $urandom_range(0, 8);
      if (p > 4095)
        p = 4095;
    end
    return PERIOD_W'(p);
  endfunction

  function automatic void setup_channel(int ch);
    logic [PERIOD_W-1:0] per;
    logic [DATA_W-1:0] ctrl;
    per = pick_period();
    if (ch < 2)
      ctrl = {($urandom_range(0, 7) == 0), 3'($urandom), 4'($urandom)};
    else
      ctrl = DATA_W'($urandom);
    queue_item(OP_WRITE, chan_addr(ch, REG_CTRL), ctrl);
    queue_item(OP_WRITE, chan_addr(ch, REG_LO), per[7:0]);
    queue_item(OP_WRITE, chan_addr(ch, REG_HI),
               {($urandom_range(0, 7) != 0), 3'($urandom), per[11:8]});
  endfunction

  function automatic void queue_random_phase(int count);
    int n;
    int kind;
    int len;
    logic [1:0] sel;
    n = 0;
    while (n < count) begin
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        // noise: mostly unmapped, not counted
        queue_item(OP_WRITE, ADDR_W'($urandom), DATA_W'($urandom));
      end else if (kind < 28) begin
        setup_channel($urandom_range(0, 2));
        n += 3;
      end else if (kind < 40) begin
        sel = ($urandom_range(0, 2) == 0) ? REG_CTRL : ($urandom_range(0, 1) ? REG_LO : REG_HI);
        queue_item(OP_WRITE, chan_addr($urandom_range(0, 2), sel), DATA_W'($urandom));
        n++;
      end else begin
        len = $urandom_range(1, 40);
        repeat (len) queue_item(OP_TICK, ADDR_W'($urandom), DATA_W'($urandom));
        n += len;
      end
    end
  endfunction

  function automatic void queue_directed();
    queue_item(OP_TICK, 16'h0000, 8'h00);
    queue_item(OP_WRITE, chan_addr(0, REG_CTRL), 8'h7F);  // full volume, widest duty
    queue_item(OP_WRITE, chan_addr(0, REG_LO), 8'h04);
    queue_item(OP_WRITE, chan_addr(0, REG_HI), 8'h80);    // period at the threshold
    repeat (6) queue_item(OP_TICK, 16'hFFFF, 8'hFF);
    queue_item(OP_WRITE, chan_addr(1, REG_CTRL), 8'h8F);  // digital mode mutes
    queue_item(OP_WRITE, chan_addr(1, REG_LO), 8'hFF);
    queue_item(OP_WRITE, chan_addr(1, REG_HI), 8'h8F);    // largest period
    queue_item(OP_WRITE, chan_addr(2, REG_CTRL), 8'hFF);  // largest rate
    queue_item(OP_WRITE, chan_addr(2, REG_LO), 8'h04);
    queue_item(OP_WRITE, chan_addr(2, REG_HI), 8'h80);
    repeat (3) queue_item(OP_TICK, 16'h0000, 8'h00);
    queue_item(OP_WRITE, chan_addr(0, REG_UNUSED), 8'hFF);
    queue_item(OP_WRITE, 16'hFFFF, 8'hFF);
    queue_item(OP_WRITE, 16'h0000, 8'h00);
    queue_item(OP_WRITE, chan_addr(0, REG_LO), 8'h03);    // below threshold: silent
    queue_item(OP_TICK, 16'h0000, 8'h00);
    queue_item(OP_WRITE, chan_addr(1, REG_CTRL), 8'h00);  // volume zero
  endfunction

  task automatic write_setting(logic [CFG_IDX_W-1:0] idx, int value);
    @(negedge clk_i);
    cfg_if.index <= idx;
    cfg_if.data  <= CFG_DATA_W'(value);
    cfg_if.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
    if (idx == CFG_SWAP_ADDR)
      swap_lines = value[0];
    else
      min_per = PERIOD_W'(value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic wait_all_results();
    while (results_seen != items_queued) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Item driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_fire) begin
      if (in_gap != 0) begin
        in_if.valid <= 1'b0;
        in_gap--;
      end else if (pending_items_q.size() != 0) begin
        next_item = pending_items_q.pop_front();
        in_if.opcode     <= next_item.opcode;
        in_if.address    <= next_item.address;
        in_if.write_data <= next_item.write_data;
        in_if.valid      <= 1'b1;
        if ($urandom_range(0, 39) == 0)
          in_idle_on = !in_idle_on;
        in_gap = in_idle_on ? $urandom_range(0, 13) : 0;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result back-pressure, one stall draw per transfer
  always @(negedge clk_i) begin
    if (out_fire) begin
      if ($urandom_range(0, 39) == 0)
        out_idle_on = !out_idle_on;
      out_wait = out_idle_on ? $urandom_range(0, 13) : 0;
    end
    if (out_wait != 0) begin
      out_if.ready <= 1'b0;
      out_wait--;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Monitor and checker
  always @(posedge clk_i) begin
    in_fire  <= rst_ni && in_if.valid && in_if.ready;
    out_fire <= rst_ni && out_if.valid && out_if.ready;
    if (rst_ni && in_if.valid && in_if.ready) begin
      taken_item.opcode     = in_if.opcode;
      taken_item.address    = in_if.address;
      taken_item.write_data = in_if.write_data;
      expected_levels_q.push_back(predict_levels(taken_item));
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      results_seen++;
      if (expected_levels_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual a=%0d b=%0d saw=%0d mix=%0d",
                 $time, out_if.pulse_level_a, out_if.pulse_level_b, out_if.saw_level,
                 out_if.mixed_level);
        mismatches++;
      end else begin
        want_levels = expected_levels_q.pop_front();
        report_field("pulse_level_a", want_levels.level_a, out_if.pulse_level_a);
        report_field("pulse_level_b", want_levels.level_b, out_if.pulse_level_b);
        report_field("saw_level", want_levels.saw, out_if.saw_level);
        report_field("mixed_level", want_levels.mix, out_if.mixed_level);
      end
    end
  end

  // Watchdog: cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, items_queued - results_seen);
      $display("pulse_saw_sound_generator: mismatch");
      $finish;
    end
  end

  initial begin
    int swap_set [NUM_PHASES];
    int min_set [NUM_PHASES];
    in_if.valid      = 1'b0;
    in_if.opcode     = OP_TICK;
    in_if.address    = '0;
    in_if.write_data = '0;
    out_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = CFG_SWAP_ADDR;
    cfg_if.data      = '0;

    swap_lines = 1'b0;
    min_per    = MIN_PERIOD_RST;
    for (int c = 0; c < 2; c++) begin
      p_vol[c]  = '0;
      p_duty[c] = DUTY_W'(1);
      p_dig[c]  = 1'b0;
      p_per[c]  = PERIOD_W'(1);
      p_en[c]   = 1'b0;
      p_cnt[c]  = '0;
      p_step[c] = '0;
    end
    s_rate = '0;
    s_per  = PERIOD_W'(1);
    s_en   = 1'b0;
    s_cnt  = '0;
    s_step = '0;
    s_acc  = '0;

    swap_set = '{0, 1, 0, 1, 0};
    min_set  = '{int'(MIN_PERIOD_RST), 0, 4095, $urandom_range(1, 12), 2};

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_setting(CFG_SWAP_ADDR, swap_set[ph]);
      write_setting(CFG_MIN_PERIOD, min_set[ph]);
      if (ph == 0)
        queue_directed();
      queue_random_phase(ITEMS_PER_PHASE);
      wait_all_results();
    end

    if (expected_levels_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_levels_q.size());
      mismatches++;
    end
    if (mismatches == 0)
      $display("pulse_saw_sound_generator: match");
    else
      $display("pulse_saw_sound_generator: mismatch");
    $finish;
  end

endmodule
